// File: sv/iptc_pkg.sv
// Package with the types, codes and limits shared by the IP address text classifier.
`timescale 1ns / 1ps

package iptc_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned VerdictW  = 2;
  localparam int unsigned LenW      = 6;
  localparam int unsigned DotW      = 3;
  localparam int unsigned ColonW    = 4;
  localparam int unsigned ValW      = 9;
  localparam int unsigned DigW      = 3;

  localparam logic [ValW-1:0]   V4MaxValue  = 9'd255;
  localparam logic [LenW-1:0]   V4MaxLen    = 6'd15;
  localparam logic [LenW-1:0]   V6MaxLen    = 6'd39;
  localparam logic [DigW-1:0]   V6MaxDigits = 3'd4;
  localparam logic [ColonW-1:0] V6Colons    = 4'd7;
  localparam logic [DotW-1:0]   V4Dots      = 3'd3;

  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChZero  = 8'h30;

  localparam logic ActChar = 1'b0;
  localparam logic ActEnd  = 1'b1;

  localparam logic [VerdictW-1:0] VerdictNone = 2'd0;
  localparam logic [VerdictW-1:0] VerdictV4   = 2'd1;
  localparam logic [VerdictW-1:0] VerdictV6   = 2'd2;

  typedef struct packed {
    logic             action;
    logic [CharW-1:0] character;
  } item_t;

endpackage

// File: sv/iptc_core.sv
// Per-character scanning state and the end-of-string verdict logic.
`timescale 1ns / 1ps

module iptc_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  iptc_pkg::item_t                   item,
  output logic [iptc_pkg::VerdictW-1:0]     verdict
);

  logic [iptc_pkg::LenW-1:0]   char_count_r,   char_count_nxt;
  logic [iptc_pkg::DotW-1:0]   dot_count_r,    dot_count_nxt;
  logic [iptc_pkg::ColonW-1:0] colon_count_r,  colon_count_nxt;
  logic                        v4_ok_r,        v4_ok_nxt;
  logic [iptc_pkg::ValW-1:0]   v4_val_r,       v4_val_nxt;
  logic [iptc_pkg::DigW-1:0]   v4_dig_r,       v4_dig_nxt;
  logic                        v4_zero_r,      v4_zero_nxt;
  logic                        v6_ok_r,        v6_ok_nxt;
  logic [iptc_pkg::DigW-1:0]   v6_dig_r,       v6_dig_nxt;

  logic [iptc_pkg::CharW-1:0] ch;
  logic                       is_dec;
  logic                       is_hexl;
  logic [3:0]                 digit;
  logic [12:0]                val_x10;
  logic [iptc_pkg::DigW-1:0]  v6_dig_inc;
  logic                       v4_final;
  logic                       v6_final;

  assign ch      = item.character;
  assign is_dec  = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_hexl = ((ch >= 8'h61) && (ch <= 8'h66)) || ((ch >= 8'h41) && (ch <= 8'h46));
  assign digit   = 4'(ch - iptc_pkg::ChZero);
  // Times ten as two shifts; the sum stays within 13 bits.
  assign val_x10 = {1'b0, v4_val_r, 3'b000} + {3'b000, v4_val_r, 1'b0} + {9'd0, digit};
  assign v6_dig_inc = (v6_dig_r == '1) ? v6_dig_r : v6_dig_r + 1'b1;

  assign v4_final = v4_ok_r && (dot_count_r == iptc_pkg::V4Dots) && (colon_count_r == '0) &&
                    (char_count_r <= iptc_pkg::V4MaxLen) && (v4_dig_r != '0) &&
                    (v4_val_r <= iptc_pkg::V4MaxValue);
  assign v6_final = v6_ok_r && (colon_count_r == iptc_pkg::V6Colons) && (dot_count_r == '0) &&
                    (char_count_r <= iptc_pkg::V6MaxLen) && (v6_dig_r != '0) &&
                    (v6_dig_r <= iptc_pkg::V6MaxDigits);

  always_comb begin
    priority if (v4_final) begin
      verdict = iptc_pkg::VerdictV4;
    end else if (v6_final) begin
      verdict = iptc_pkg::VerdictV6;
    end else begin
      verdict = iptc_pkg::VerdictNone;
    end
  end

  always_comb begin
    char_count_nxt  = (char_count_r == '1) ? char_count_r : char_count_r + 1'b1;
    dot_count_nxt   = dot_count_r;
    colon_count_nxt = colon_count_r;
    v4_ok_nxt       = v4_ok_r;
    v4_val_nxt      = v4_val_r;
    v4_dig_nxt      = v4_dig_r;
    v4_zero_nxt     = v4_zero_r;
    v6_ok_nxt       = v6_ok_r;
    v6_dig_nxt      = v6_dig_r;
    priority if (item.action == iptc_pkg::ActEnd) begin
      char_count_nxt  = '0;
      dot_count_nxt   = '0;
      colon_count_nxt = '0;
      v4_ok_nxt       = 1'b1;
      v4_val_nxt      = '0;
      v4_dig_nxt      = '0;
      v4_zero_nxt     = 1'b0;
      v6_ok_nxt       = 1'b1;
      v6_dig_nxt      = '0;
    end else if (ch == iptc_pkg::ChDot) begin
      dot_count_nxt = (dot_count_r == '1) ? dot_count_r : dot_count_r + 1'b1;
      v6_ok_nxt     = 1'b0;
      if ((v4_dig_r == '0) || (v4_val_r > iptc_pkg::V4MaxValue)) begin
        v4_ok_nxt = 1'b0;
      end
      v4_val_nxt  = '0;
      v4_dig_nxt  = '0;
      v4_zero_nxt = 1'b0;
    end else if (ch == iptc_pkg::ChColon) begin
      colon_count_nxt = (colon_count_r == '1) ? colon_count_r : colon_count_r + 1'b1;
      v4_ok_nxt       = 1'b0;
      if ((v6_dig_r == '0) || (v6_dig_r > iptc_pkg::V6MaxDigits)) begin
        v6_ok_nxt = 1'b0;
      end
      v6_dig_nxt = '0;
    end else if (is_dec) begin
      // A second digit after a leading zero breaks the dotted-decimal form.
      if ((v4_dig_r == 3'd1) && v4_zero_r) begin
        v4_ok_nxt = 1'b0;
      end
      if (v4_dig_r == '0) begin
        v4_zero_nxt = (digit == 4'd0);
      end
      v4_val_nxt = (val_x10 > 13'd511) ? '1 : val_x10[iptc_pkg::ValW-1:0];
      if ((val_x10 > 13'({1'b0, iptc_pkg::V4MaxValue}))) begin
        v4_ok_nxt = 1'b0;
      end
      v4_dig_nxt = (v4_dig_r == '1) ? v4_dig_r : v4_dig_r + 1'b1;
      v6_dig_nxt = v6_dig_inc;
      if (v6_dig_inc > iptc_pkg::V6MaxDigits) begin
        v6_ok_nxt = 1'b0;
      end
    end else if (is_hexl) begin
      v4_ok_nxt  = 1'b0;
      v6_dig_nxt = v6_dig_inc;
      if (v6_dig_inc > iptc_pkg::V6MaxDigits) begin
        v6_ok_nxt = 1'b0;
      end
    end else begin
      v4_ok_nxt = 1'b0;
      v6_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r  <= '0;
      dot_count_r   <= '0;
      colon_count_r <= '0;
      v4_ok_r       <= 1'b1;
      v4_val_r      <= '0;
      v4_dig_r      <= '0;
      v4_zero_r     <= 1'b0;
      v6_ok_r       <= 1'b1;
      v6_dig_r      <= '0;
    end else if (step) begin
      char_count_r  <= char_count_nxt;
      dot_count_r   <= dot_count_nxt;
      colon_count_r <= colon_count_nxt;
      v4_ok_r       <= v4_ok_nxt;
      v4_val_r      <= v4_val_nxt;
      v4_dig_r      <= v4_dig_nxt;
      v4_zero_r     <= v4_zero_nxt;
      v6_ok_r       <= v6_ok_nxt;
      v6_dig_r      <= v6_dig_nxt;
    end
  end

endmodule

// File: sv/ip_address_text_classifier.sv
// Top level of the IP address text classifier: input register, scanner and result register.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   in_action, in_character
//   out_      output     out_valid / out_stall out_verdict
//
// One item is taken per clock while in_stall is low; characters never produce a transfer on out_.
// An end marker's verdict reaches out_ through the input register and then the result register.
// rst_n is synchronous and clears the scan state and both valid flags.
// out_stall holds the result; in_stall rises only while an end marker waits
// in the input register behind a stalled result.
`timescale 1ns / 1ps

module ip_address_text_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [iptc_pkg::CharW-1:0]    in_character,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [iptc_pkg::VerdictW-1:0] out_verdict
);

  logic                          s1_valid_r;
  iptc_pkg::item_t               s1_item_r;
  logic                          s1_go;
  logic                          out_free;
  logic [iptc_pkg::VerdictW-1:0] verdict;
  logic                          out_valid_r;
  logic [iptc_pkg::VerdictW-1:0] out_verdict_r;

  assign out_free = !out_valid_r || !out_stall;
  // Characters always advance; an end marker needs room in the result register.
  assign s1_go    = s1_valid_r && ((s1_item_r.action == iptc_pkg::ActChar) || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  iptc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .item    (s1_item_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r.action    <= in_action;
      s1_item_r.character <= in_character;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && (s1_item_r.action == iptc_pkg::ActEnd);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && (s1_item_r.action == iptc_pkg::ActEnd)) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

// File: sv/iptc_checker.sv
// Port-level checker for the IP address text classifier and its bind.
`timescale 1ns / 1ps

module iptc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [iptc_pkg::VerdictW-1:0] out_verdict
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_verdict))
    else $error("result changed while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == iptc_pkg::VerdictNone) ||
                  (out_verdict == iptc_pkg::VerdictV4) ||
                  (out_verdict == iptc_pkg::VerdictV6))
    else $error("undefined verdict code");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid && !in_stall)
    else $error("result or stall present right after reset");

endmodule

bind ip_address_text_classifier iptc_checker u_iptc_checker (.*);
